// ----- design/rtp_pkg.sv -----
`timescale 1ns / 1ps

package rtp_pkg;

   localparam int OCTAVE_SHIFT = 0;
   localparam int TABLE_NOTES  = 48;

   localparam int CHAR_W     = 8;
   localparam int ACC_W      = 10;
   localparam int DUR_W      = 8;
   localparam int OCT_W      = 3;
   localparam int TEMPO_W    = 10;
   localparam int WHOLE_W    = 18;
   localparam int PDUR_W     = 19;
   localparam int SEMI_W     = 4;
   localparam int POCT_W     = 4;
   localparam int PITCH_W    = 6;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int DIV_DEND_W = 18;
   localparam int DIV_SOR_W  = 10;
   localparam int DIV_STEPS  = DIV_DEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [DUR_W-1:0]   RESET_DURATION = 8'd4;
   localparam logic [OCT_W-1:0]   RESET_OCTAVE   = 3'd6;
   localparam logic [TEMPO_W-1:0] RESET_TEMPO    = 10'd63;

   localparam logic [DIV_DEND_W-1:0] MS_PER_MINUTE = 18'd60000;
   localparam logic [ACC_W-1:0]      ACC_MAX       = 10'd1023;
   localparam logic [DUR_W-1:0]      DUR_MAX       = 8'd255;
   localparam int                    ACC_RADIX     = 10;

   localparam logic [CHAR_W-1:0] CHAR_END    = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_COLON  = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_SHARP  = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_THREE  = 8'h33;
   localparam logic [CHAR_W-1:0] CHAR_SEVEN  = 8'h37;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_B = 8'h62;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_C = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_D = 8'h64;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_E = 8'h65;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_G = 8'h67;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_O = 8'h6F;

   localparam logic [1:0] CSR_DURATION = 2'd0;
   localparam logic [1:0] CSR_OCTAVE   = 2'd1;
   localparam logic [1:0] CSR_TEMPO    = 2'd2;

   typedef struct packed {
      logic [DUR_W-1:0]   duration;
      logic [OCT_W-1:0]   octave;
      logic [TEMPO_W-1:0] tempo;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_DEND_W-1:0] dividend;
      logic [DIV_SOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIV_DEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- design/rtp_divider.sv -----
`timescale 1ns / 1ps

module rtp_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rtp_pkg::div_req_type div_req,
   output rtp_pkg::div_rsp_type div_rsp
);
   import rtp_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIV_SOR_W-1:0]  rem_ff, rem_in;
   logic [DIV_SOR_W-1:0]  sor_ff, sor_in;
   logic [DIV_DEND_W-1:0] quo_ff, quo_in;
   logic [DIV_SOR_W:0]    trial;
   logic                  fits;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      sor_in   = sor_ff;
      quo_in   = quo_ff;
      trial    = {rem_ff, quo_ff[DIV_DEND_W-1]};
      fits     = trial >= {1'b0, sor_ff};
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(DIV_STEPS);
         rem_in   = '0;
         sor_in   = div_req.divisor;
         quo_in   = div_req.dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? DIV_SOR_W'(trial - {1'b0, sor_ff}) : trial[DIV_SOR_W-1:0];
         quo_in   = {quo_ff[DIV_DEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      sor_ff <= sor_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- design/rtp_csr.sv -----
`timescale 1ns / 1ps

module rtp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rtp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rtp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rtp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output rtp_pkg::cfg_type                 cfg
);
   import rtp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] index;
   logic       wr_en;

   assign index = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_DURATION: cfg_in.duration = csr_pwdata[DUR_W-1:0];
            CSR_OCTAVE:   cfg_in.octave   = csr_pwdata[OCT_W-1:0];
            CSR_TEMPO:    cfg_in.tempo    = csr_pwdata[TEMPO_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_DURATION: csr_prdata = CSR_DATA_W'(cfg_ff.duration);
         CSR_OCTAVE:   csr_prdata = CSR_DATA_W'(cfg_ff.octave);
         CSR_TEMPO:    csr_prdata = CSR_DATA_W'(cfg_ff.tempo);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duration <= RESET_DURATION;
         cfg_ff.octave   <= RESET_OCTAVE;
         cfg_ff.tempo    <= RESET_TEMPO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ----- design/rtp_parser.sv -----
`timescale 1ns / 1ps

module rtp_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  rtp_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rtp_pkg::CHAR_W-1:0]      req_character,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rtp_pkg::PITCH_W-1:0]     rsp_pitch_index,
   output logic [rtp_pkg::SEMI_W-1:0]      rsp_semitone,
   output logic [rtp_pkg::POCT_W-1:0]      rsp_octave,
   output logic [rtp_pkg::PDUR_W-1:0]      rsp_duration_ms,
   output logic                            rsp_pitch_invalid,
   output logic                            rsp_song_end,
   output rtp_pkg::div_req_type            div_req,
   input  rtp_pkg::div_rsp_type            div_rsp
);
   import rtp_pkg::*;

   typedef enum logic [4:0] {
      SEQ_IDLE  = 5'b00001,
      SEQ_RUN   = 5'b00010,
      SEQ_WHOLE = 5'b00100,
      SEQ_NOTE  = 5'b01000,
      SEQ_EMIT  = 5'b10000
   } seq_type;

   typedef enum logic [15:0] {
      PH_NAME   = 16'h0001,
      PH_DCHK   = 16'h0002,
      PH_DEQ    = 16'h0004,
      PH_DNUM   = 16'h0008,
      PH_OCHK   = 16'h0010,
      PH_OEQ    = 16'h0020,
      PH_OVAL   = 16'h0040,
      PH_OSEP   = 16'h0080,
      PH_BCHK   = 16'h0100,
      PH_BEQ    = 16'h0200,
      PH_BNUM   = 16'h0400,
      PH_NSTART = 16'h0800,
      PH_NLET   = 16'h1000,
      PH_NSHARP = 16'h2000,
      PH_NDOT   = 16'h4000,
      PH_NOCT   = 16'h8000
   } phase_type;

   seq_type             seq_ff, seq_in;
   phase_type           phase_ff, phase_in;
   logic                cont_ff, cont_in;
   logic                end_ff, end_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [DUR_W-1:0]    dur_def_ff, dur_def_in;
   logic [OCT_W-1:0]    oct_def_ff, oct_def_in;
   logic [TEMPO_W-1:0]  tempo_ff, tempo_in;
   logic [WHOLE_W-1:0]  whole_ff, whole_in;
   logic [SEMI_W-1:0]   semi_ff, semi_in;
   logic [PDUR_W-1:0]   pdur_ff, pdur_in;
   logic [POCT_W-1:0]   poct_ff, poct_in;

   logic                out_valid_ff, out_valid_in;
   logic [PITCH_W-1:0]  out_pitch_ff, out_pitch_in;
   logic [SEMI_W-1:0]   out_semi_ff, out_semi_in;
   logic [POCT_W-1:0]   out_oct_ff, out_oct_in;
   logic [PDUR_W-1:0]   out_dur_ff, out_dur_in;
   logic                out_bad_ff, out_bad_in;
   logic                out_end_ff, out_end_in;

   logic                is_digit;
   logic                in_note;
   logic [13:0]         acc_sum;
   logic [ACC_W-1:0]    acc_next;
   logic [TEMPO_W-1:0]  div_tempo;
   logic [ACC_W-1:0]    note_div;
   logic [SEMI_W-1:0]   letter_semi;
   logic                out_free;
   logic [4:0]          scale;
   logic signed [7:0]   scale_s;
   logic signed [7:0]   note_pos;
   logic                pos_ok;

   assign is_digit = char_ff >= CHAR_ZERO && char_ff <= CHAR_NINE;
   assign in_note  = phase_ff == PH_NLET || phase_ff == PH_NSHARP ||
                     phase_ff == PH_NDOT || phase_ff == PH_NOCT;
   assign acc_sum  = 14'(acc_ff) * 14'(ACC_RADIX) + 14'(char_ff[3:0]);
   assign acc_next = (acc_sum > 14'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      case (char_ff)
         CHAR_LOWER_A: letter_semi = 4'd10;
         CHAR_LOWER_B: letter_semi = 4'd12;
         CHAR_LOWER_C: letter_semi = 4'd1;
         CHAR_LOWER_D: letter_semi = 4'd3;
         CHAR_LOWER_E: letter_semi = 4'd5;
         CHAR_LOWER_F: letter_semi = 4'd6;
         CHAR_LOWER_G: letter_semi = 4'd8;
         default:      letter_semi = 4'd0;
      endcase
   end

   assign scale    = 5'(poct_ff) + 5'(OCTAVE_SHIFT);
   assign scale_s  = $signed(8'(scale));
   assign note_pos = (scale_s - 8'sd4) * 8'sd12 + $signed(8'(semi_ff));
   assign pos_ok   = note_pos > 8'sd0 && note_pos <= $signed(8'(TABLE_NOTES));

   always_comb begin
      seq_in     = seq_ff;
      phase_in   = phase_ff;
      cont_in    = cont_ff;
      end_in     = end_ff;
      char_in    = char_ff;
      acc_in     = acc_ff;
      dur_def_in = dur_def_ff;
      oct_def_in = oct_def_ff;
      tempo_in   = tempo_ff;
      whole_in   = whole_ff;
      semi_in    = semi_ff;
      pdur_in    = pdur_ff;
      poct_in    = poct_ff;
      div_tempo  = tempo_ff;
      note_div   = '0;
      div_req.start    = 1'b0;
      div_req.dividend = MS_PER_MINUTE;
      div_req.divisor  = '0;

      out_valid_in = out_valid_ff && rsp_stall;
      out_pitch_in = out_pitch_ff;
      out_semi_in  = out_semi_ff;
      out_oct_in   = out_oct_ff;
      out_dur_in   = out_dur_ff;
      out_bad_in   = out_bad_ff;
      out_end_in   = out_end_ff;

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               char_in = req_character;
               seq_in  = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            seq_in = SEQ_IDLE;
            if (char_ff == CHAR_END) begin
               if (in_note) begin
                  end_in = 1'b1;
                  seq_in = SEQ_EMIT;
               end else begin
                  phase_in   = PH_NAME;
                  dur_def_in = cfg.duration;
                  oct_def_in = cfg.octave;
                  tempo_in   = cfg.tempo;
                  acc_in     = '0;
                  whole_in   = '0;
                  semi_in    = '0;
                  pdur_in    = '0;
                  poct_in    = '0;
               end
            end else begin
               unique case (phase_ff)
                  PH_NAME: begin
                     if (char_ff == CHAR_COLON) begin
                        dur_def_in = cfg.duration;
                        oct_def_in = cfg.octave;
                        tempo_in   = cfg.tempo;
                        acc_in     = '0;
                        whole_in   = '0;
                        semi_in    = '0;
                        pdur_in    = '0;
                        poct_in    = '0;
                        div_tempo  = cfg.tempo;
                        div_req.start = 1'b1;
                        phase_in   = PH_DCHK;
                        cont_in    = 1'b0;
                        seq_in     = SEQ_WHOLE;
                     end
                  end
                  PH_DCHK: begin
                     if (char_ff == CHAR_LOWER_D) begin
                        phase_in = PH_DEQ;
                     end else begin
                        phase_in = PH_OCHK;
                        seq_in   = SEQ_RUN;
                     end
                  end
                  PH_DEQ: begin
                     acc_in   = '0;
                     phase_in = PH_DNUM;
                  end
                  PH_DNUM: begin
                     if (is_digit) begin
                        acc_in = acc_next;
                     end else begin
                        if (acc_ff != '0) begin
                           dur_def_in = (acc_ff > ACC_W'(DUR_MAX)) ? DUR_MAX
                                                                   : acc_ff[DUR_W-1:0];
                        end
                        acc_in   = '0;
                        phase_in = PH_OCHK;
                     end
                  end
                  PH_OCHK: begin
                     if (char_ff == CHAR_LOWER_O) begin
                        phase_in = PH_OEQ;
                     end else begin
                        phase_in = PH_BCHK;
                        seq_in   = SEQ_RUN;
                     end
                  end
                  PH_OEQ: begin
                     phase_in = PH_OVAL;
                  end
                  PH_OVAL: begin
                     if (char_ff >= CHAR_THREE && char_ff <= CHAR_SEVEN) begin
                        oct_def_in = char_ff[OCT_W-1:0];
                     end
                     phase_in = PH_OSEP;
                  end
                  PH_OSEP: begin
                     phase_in = PH_BCHK;
                  end
                  PH_BCHK: begin
                     if (char_ff == CHAR_LOWER_B) begin
                        phase_in = PH_BEQ;
                     end else begin
                        acc_in        = '0;
                        div_tempo     = tempo_ff;
                        div_req.start = 1'b1;
                        phase_in      = PH_NSTART;
                        cont_in       = 1'b1;
                        seq_in        = SEQ_WHOLE;
                     end
                  end
                  PH_BEQ: begin
                     acc_in   = '0;
                     phase_in = PH_BNUM;
                  end
                  PH_BNUM: begin
                     if (is_digit) begin
                        acc_in = acc_next;
                     end else begin
                        tempo_in      = (acc_ff == '0) ? TEMPO_W'(1) : acc_ff;
                        div_tempo     = tempo_in;
                        div_req.start = 1'b1;
                        acc_in        = '0;
                        phase_in      = PH_NSTART;
                        cont_in       = 1'b0;
                        seq_in        = SEQ_WHOLE;
                     end
                  end
                  PH_NSTART: begin
                     if (is_digit) begin
                        acc_in = acc_next;
                     end else begin
                        note_div         = (acc_ff != '0) ? acc_ff : ACC_W'(dur_def_ff);
                        div_req.start    = 1'b1;
                        div_req.dividend = whole_ff;
                        div_req.divisor  = (note_div == '0) ? DIV_SOR_W'(1) : note_div;
                        semi_in          = letter_semi;
                        poct_in          = POCT_W'(oct_def_ff);
                        acc_in           = '0;
                        phase_in         = PH_NLET;
                        seq_in           = SEQ_NOTE;
                     end
                  end
                  PH_NLET, PH_NSHARP, PH_NDOT, PH_NOCT: begin
                     if (char_ff == CHAR_SHARP && phase_ff == PH_NLET) begin
                        semi_in  = semi_ff + 1'b1;
                        phase_in = PH_NSHARP;
                     end else if (char_ff == CHAR_DOT &&
                                  (phase_ff == PH_NLET || phase_ff == PH_NSHARP)) begin
                        pdur_in  = pdur_ff + (pdur_ff >> 1);
                        phase_in = PH_NDOT;
                     end else if (is_digit && phase_ff != PH_NOCT) begin
                        poct_in  = char_ff[POCT_W-1:0];
                        phase_in = PH_NOCT;
                     end else begin
                        end_in = 1'b0;
                        seq_in = SEQ_EMIT;
                     end
                  end
                  default: begin
                     phase_in = PH_NAME;
                  end
               endcase
            end
            if (div_req.start && !(phase_ff == PH_NSTART)) begin
               div_req.dividend = MS_PER_MINUTE;
               div_req.divisor  = (div_tempo == '0) ? DIV_SOR_W'(1) : div_tempo;
            end
         end
         SEQ_WHOLE: begin
            if (div_rsp.done) begin
               whole_in = {div_rsp.quotient[WHOLE_W-3:0], 2'b00};
               seq_in   = cont_ff ? SEQ_RUN : SEQ_IDLE;
            end
         end
         SEQ_NOTE: begin
            if (div_rsp.done) begin
               pdur_in = PDUR_W'(div_rsp.quotient);
               seq_in  = SEQ_IDLE;
            end
         end
         SEQ_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_pitch_in = (semi_ff != '0 && pos_ok) ? note_pos[PITCH_W-1:0] : '0;
               out_semi_in  = semi_ff;
               out_oct_in   = scale[POCT_W-1:0];
               out_dur_in   = pdur_ff;
               out_bad_in   = semi_ff != '0 && !pos_ok;
               out_end_in   = end_ff;
               if (end_ff) begin
                  phase_in   = PH_NAME;
                  dur_def_in = cfg.duration;
                  oct_def_in = cfg.octave;
                  tempo_in   = cfg.tempo;
                  acc_in     = '0;
                  whole_in   = '0;
                  semi_in    = '0;
                  pdur_in    = '0;
                  poct_in    = '0;
                  seq_in     = SEQ_IDLE;
               end else begin
                  acc_in   = '0;
                  phase_in = PH_NSTART;
                  seq_in   = (char_ff == CHAR_COMMA) ? SEQ_IDLE : SEQ_RUN;
               end
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         phase_ff     <= PH_NAME;
         cont_ff      <= 1'b0;
         end_ff       <= 1'b0;
         acc_ff       <= '0;
         dur_def_ff   <= RESET_DURATION;
         oct_def_ff   <= RESET_OCTAVE;
         tempo_ff     <= RESET_TEMPO;
         whole_ff     <= '0;
         semi_ff      <= '0;
         pdur_ff      <= '0;
         poct_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         cont_ff      <= cont_in;
         end_ff       <= end_in;
         acc_ff       <= acc_in;
         dur_def_ff   <= dur_def_in;
         oct_def_ff   <= oct_def_in;
         tempo_ff     <= tempo_in;
         whole_ff     <= whole_in;
         semi_ff      <= semi_in;
         pdur_ff      <= pdur_in;
         poct_ff      <= poct_in;
         out_valid_ff <= out_valid_in;
      end
      char_ff      <= char_in;
      out_pitch_ff <= out_pitch_in;
      out_semi_ff  <= out_semi_in;
      out_oct_ff   <= out_oct_in;
      out_dur_ff   <= out_dur_in;
      out_bad_ff   <= out_bad_in;
      out_end_ff   <= out_end_in;
   end

   assign req_stall         = seq_ff != SEQ_IDLE;
   assign rsp_valid         = out_valid_ff;
   assign rsp_pitch_index   = out_pitch_ff;
   assign rsp_semitone      = out_semi_ff;
   assign rsp_octave        = out_oct_ff;
   assign rsp_duration_ms   = out_dur_ff;
   assign rsp_pitch_invalid = out_bad_ff;
   assign rsp_song_end      = out_end_ff;

endmodule

// ----- design/rtttl_ringtone_parser.sv -----
// A character is taken only while the parser is idle; req_stall is high until it is ready again,
// and a character that skips a missing header field is parsed again. The ':' after the name,
// the end of the header and each note letter run the shared 18-step divider. A note event
// reaches the output register from the emit state after the byte that ends it is parsed; the
// longest wait is for a note letter right after ':' with no header; an output stall adds to it.
// Reset is synchronous: registers return to defaults and the parser waits for the name.
`timescale 1ns / 1ps

module rtttl_ringtone_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rtp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rtp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rtp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rtp_pkg::CHAR_W-1:0]      req_character,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rtp_pkg::PITCH_W-1:0]     rsp_pitch_index,
   output logic [rtp_pkg::SEMI_W-1:0]      rsp_semitone,
   output logic [rtp_pkg::POCT_W-1:0]      rsp_octave,
   output logic [rtp_pkg::PDUR_W-1:0]      rsp_duration_ms,
   output logic                            rsp_pitch_invalid,
   output logic                            rsp_song_end
);
   import rtp_pkg::*;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   rtp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rtp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rtp_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_character     (req_character),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pitch_index   (rsp_pitch_index),
      .rsp_semitone      (rsp_semitone),
      .rsp_octave        (rsp_octave),
      .rsp_duration_ms   (rsp_duration_ms),
      .rsp_pitch_invalid (rsp_pitch_invalid),
      .rsp_song_end      (rsp_song_end),
      .div_req           (div_req),
      .div_rsp           (div_rsp)
   );

endmodule

// ----- bench/tb_rtttl_ringtone_parser.sv -----
`timescale 1ns / 1ps

module tb_rtttl_ringtone_parser;
   import rtp_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASES       = 7;
   localparam int PHASE_CHARS  = 220;

   localparam logic [CHAR_W-1:0] CHAR_EQUALS = 8'h3D;
   localparam logic [CHAR_W-1:0] REST_LETTER = 8'h70;

   typedef enum logic [3:0] {
      SKIP_NAME, D_KEY, D_EQ, D_NUM, O_KEY, O_EQ, O_VAL, O_SEP,
      B_KEY, B_EQ, B_NUM, TOK_START, TOK_LETTER, TOK_SHARP, TOK_DOT, TOK_OCT
   } parse_phase_type;

   typedef struct packed {
      logic [PITCH_W-1:0] pitch_index;
      logic [SEMI_W-1:0]  semitone;
      logic [POCT_W-1:0]  octave;
      logic [PDUR_W-1:0]  duration_ms;
      logic               pitch_invalid;
      logic               song_end;
   } note_event_type;

   class rtttl_note_tracker;
      logic [DUR_W-1:0]   cfg_duration;
      logic [OCT_W-1:0]   cfg_octave;
      logic [TEMPO_W-1:0] cfg_tempo;
      parse_phase_type    phase;
      int unsigned        acc;
      logic [DUR_W-1:0]   song_dur;
      logic [OCT_W-1:0]   song_oct;
      logic [TEMPO_W-1:0] tempo;
      int unsigned        whole_ms;
      logic [SEMI_W-1:0]  semi;
      int unsigned        pend_dur;
      logic [POCT_W-1:0]  pend_oct;
      note_event_type     due_notes[$];
      int unsigned        mismatches;
      int unsigned        events_checked;
      int unsigned        songs_ended;

      function new();
         cfg_duration = RESET_DURATION;
         cfg_octave = RESET_OCTAVE;
         cfg_tempo = RESET_TEMPO;
         phase = SKIP_NAME;
         mismatches = 0;
         events_checked = 0;
         songs_ended = 0;
         load_song();
      endfunction

      function void set_register(logic [1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_DURATION: cfg_duration = value[DUR_W-1:0];
            CSR_OCTAVE:   cfg_octave = value[OCT_W-1:0];
            CSR_TEMPO:    cfg_tempo = value[TEMPO_W-1:0];
            default: ;
         endcase
      endfunction

      function int outstanding();
         return due_notes.size();
      endfunction

      function bit is_digit(logic [CHAR_W-1:0] c);
         return c >= CHAR_ZERO && c <= CHAR_NINE;
      endfunction

      function void accumulate(logic [CHAR_W-1:0] c);
         int unsigned v;
         v = acc * ACC_RADIX + (c - CHAR_ZERO);
         acc = (v > ACC_MAX) ? ACC_MAX : v;
      endfunction

      function void load_song();
         song_dur = cfg_duration;
         song_oct = cfg_octave;
         tempo = cfg_tempo;
         acc = 0;
         whole_ms = 0;
         semi = '0;
         pend_dur = 0;
         pend_oct = '0;
      endfunction

      function void compute_whole();
         int unsigned t;
         t = (tempo == 0) ? 1 : tempo;
         whole_ms = (int'(MS_PER_MINUTE) / t) * 4;
      endfunction

      function logic [SEMI_W-1:0] semitone_of(logic [CHAR_W-1:0] c);
         case (c)
            CHAR_LOWER_A: return 4'd10;
            CHAR_LOWER_B: return 4'd12;
            CHAR_LOWER_C: return 4'd1;
            CHAR_LOWER_D: return 4'd3;
            CHAR_LOWER_E: return 4'd5;
            CHAR_LOWER_F: return 4'd6;
            CHAR_LOWER_G: return 4'd8;
            default:      return 4'd0;
         endcase
      endfunction

      function void start_note(logic [CHAR_W-1:0] c);
         int unsigned div;
         div = (acc != 0) ? acc : song_dur;
         if (div == 0) div = 1;
         pend_dur = whole_ms / div;
         semi = semitone_of(c);
         pend_oct = POCT_W'(song_oct);
         acc = 0;
         phase = TOK_LETTER;
      endfunction

      function note_event_type make_event(bit at_end);
         note_event_type ev;
         int scale;
         int p;
         ev = '0;
         scale = int'(pend_oct) + OCTAVE_SHIFT;
         if (semi != 0) begin
            p = (scale - 4) * 12 + int'(semi);
            if (p >= 1 && p <= TABLE_NOTES) ev.pitch_index = PITCH_W'(p);
            else ev.pitch_invalid = 1'b1;
         end
         ev.semitone = semi;
         ev.octave = POCT_W'(scale);
         ev.duration_ms = PDUR_W'(pend_dur);
         ev.song_end = at_end;
         return ev;
      endfunction

      function void parse_char(logic [CHAR_W-1:0] c);
         if (c == CHAR_END) begin
            if (phase >= TOK_LETTER) due_notes.push_back(make_event(1'b1));
            phase = SKIP_NAME;
            load_song();
            songs_ended++;
            return;
         end
         forever begin
            case (phase)
               SKIP_NAME: begin
                  if (c == CHAR_COLON) begin
                     load_song();
                     compute_whole();
                     phase = D_KEY;
                  end
                  return;
               end
               D_KEY: begin
                  if (c == CHAR_LOWER_D) begin
                     phase = D_EQ;
                     return;
                  end
                  phase = O_KEY;
               end
               D_EQ: begin
                  acc = 0;
                  phase = D_NUM;
                  return;
               end
               D_NUM: begin
                  if (is_digit(c)) begin
                     accumulate(c);
                     return;
                  end
                  if (acc > 0) song_dur = (acc > DUR_MAX) ? DUR_MAX : DUR_W'(acc);
                  acc = 0;
                  phase = O_KEY;
                  return;
               end
               O_KEY: begin
                  if (c == CHAR_LOWER_O) begin
                     phase = O_EQ;
                     return;
                  end
                  phase = B_KEY;
               end
               O_EQ: begin
                  phase = O_VAL;
                  return;
               end
               O_VAL: begin
                  if (c >= CHAR_THREE && c <= CHAR_SEVEN) song_oct = OCT_W'(c - CHAR_ZERO);
                  phase = O_SEP;
                  return;
               end
               O_SEP: begin
                  phase = B_KEY;
                  return;
               end
               B_KEY: begin
                  if (c == CHAR_LOWER_B) begin
                     phase = B_EQ;
                     return;
                  end
                  compute_whole();
                  acc = 0;
                  phase = TOK_START;
               end
               B_EQ: begin
                  acc = 0;
                  phase = B_NUM;
                  return;
               end
               B_NUM: begin
                  if (is_digit(c)) begin
                     accumulate(c);
                     return;
                  end
                  tempo = (acc == 0) ? 1 : TEMPO_W'(acc);
                  compute_whole();
                  acc = 0;
                  phase = TOK_START;
                  return;
               end
               TOK_START: begin
                  if (is_digit(c)) accumulate(c);
                  else start_note(c);
                  return;
               end
               default: begin
                  if (c == CHAR_SHARP && phase == TOK_LETTER) begin
                     semi = semi + 1'b1;
                     phase = TOK_SHARP;
                     return;
                  end
                  if (c == CHAR_DOT && (phase == TOK_LETTER || phase == TOK_SHARP)) begin
                     pend_dur = pend_dur + pend_dur / 2;
                     phase = TOK_DOT;
                     return;
                  end
                  if (is_digit(c) && phase != TOK_OCT) begin
                     pend_oct = POCT_W'(c - CHAR_ZERO);
                     phase = TOK_OCT;
                     return;
                  end
                  due_notes.push_back(make_event(1'b0));
                  acc = 0;
                  phase = TOK_START;
                  if (c == CHAR_COMMA) return;
               end
            endcase
         end
      endfunction

      function void flag(string what, note_event_type want, note_event_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: expected pitch %0d semi %0d oct %0d dur %0d bad %0b end %0b, ",
                     what, want.pitch_index, want.semitone, want.octave, want.duration_ms,
                     want.pitch_invalid, want.song_end,
                     "got pitch %0d semi %0d oct %0d dur %0d bad %0b end %0b",
                     got.pitch_index, got.semitone, got.octave, got.duration_ms,
                     got.pitch_invalid, got.song_end);
      endfunction

      function void check_event(note_event_type got);
         note_event_type want;
         if (due_notes.size() == 0) begin
            flag("note event with none due", '0, got);
            return;
         end
         want = due_notes.pop_front();
         events_checked++;
         if (got.pitch_index !== want.pitch_index || got.semitone !== want.semitone ||
             got.octave !== want.octave || got.duration_ms !== want.duration_ms ||
             got.pitch_invalid !== want.pitch_invalid || got.song_end !== want.song_end)
            flag("note event mismatch", want, got);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_character = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PITCH_W-1:0]    rsp_pitch_index;
   logic [SEMI_W-1:0]     rsp_semitone;
   logic [POCT_W-1:0]     rsp_octave;
   logic [PDUR_W-1:0]     rsp_duration_ms;
   logic                  rsp_pitch_invalid;
   logic                  rsp_song_end;

   rtttl_note_tracker tracker;
   logic [CHAR_W-1:0] song_text[$];
   int                burst_left = 0;
   int                idle_cycles = 0;
   int                chars_sent = 0;
   int                settings_written = 0;
   int                holds_done = 0;
   bit                hold_request = 1'b0;

   rtttl_ringtone_parser uut (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_character(req_character),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pitch_index(rsp_pitch_index),
      .rsp_semitone(rsp_semitone),
      .rsp_octave(rsp_octave),
      .rsp_duration_ms(rsp_duration_ms),
      .rsp_pitch_invalid(rsp_pitch_invalid),
      .rsp_song_end(rsp_song_end)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin : monitor
      note_event_type seen;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_pitch_index, rsp_semitone, rsp_octave, rsp_duration_ms,
                    rsp_pitch_invalid, rsp_song_end};
            tracker.check_event(seen);
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            tracker.parse_char(req_character);
            moved = 1'b1;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) moved = 1'b1;
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : receiver
      int mode;
      int seg_len;
      int k;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            holds_done++;
         end else begin
            mode = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 150);
            for (k = 0; k < seg_len && !hold_request; k++) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= (k % 5 < 3);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic csr_write(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.set_register(index, value);
   endtask

   task automatic apply_setting(input int dur, input int oct, input int bpm);
      csr_write(CSR_DURATION, CSR_DATA_W'(dur));
      csr_write(CSR_OCTAVE, CSR_DATA_W'(oct));
      csr_write(CSR_TEMPO, CSR_DATA_W'(bpm));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      settings_written++;
      @(posedge clock);
   endtask

   task automatic send_text();
      int gap;
      foreach (song_text[i]) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
            gap = $urandom_range(1, 15);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
         req_valid <= 1'b1;
         req_character <= song_text[i];
         @(posedge clock);
         while (req_stall) @(posedge clock);
         chars_sent++;
      end
      req_valid <= 1'b0;
      song_text.delete();
   endtask

   task automatic settle();
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] any_char();
      return CHAR_W'($urandom_range(1, 255));
   endfunction

   function automatic logic [CHAR_W-1:0] name_char();
      logic [CHAR_W-1:0] c;
      do c = any_char(); while (c == CHAR_COLON);
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] non_digit();
      logic [CHAR_W-1:0] c;
      do c = any_char(); while (c >= CHAR_ZERO && c <= CHAR_NINE);
      return c;
   endfunction

   function automatic void add_digits(input int n);
      repeat (n) song_text.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
   endfunction

   function automatic void add_number(input int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      foreach (s[i]) song_text.push_back(s[i]);
   endfunction

   function automatic void add_field(input logic [CHAR_W-1:0] key, input int typical);
      song_text.push_back(key);
      song_text.push_back(($urandom_range(0, 6) != 0) ? CHAR_EQUALS : any_char());
      case ($urandom_range(0, 9))
         0: add_digits($urandom_range(1, 5));
         1: add_number(0);
         default: add_number(typical);
      endcase
      song_text.push_back(($urandom_range(0, 4) != 0) ? CHAR_COMMA : non_digit());
   endfunction

   function automatic void add_song();
      int r;
      repeat ($urandom_range(0, 6)) song_text.push_back(name_char());
      song_text.push_back(CHAR_COLON);
      if ($urandom_range(0, 3) != 0) add_field(CHAR_LOWER_D, 1 << $urandom_range(0, 5));
      if ($urandom_range(0, 3) != 0) begin
         song_text.push_back(CHAR_LOWER_O);
         song_text.push_back(($urandom_range(0, 6) != 0) ? CHAR_EQUALS : any_char());
         song_text.push_back(($urandom_range(0, 4) != 0) ?
                             CHAR_W'(CHAR_ZERO + $urandom_range(3, 7)) : any_char());
         song_text.push_back(($urandom_range(0, 4) != 0) ? CHAR_COMMA : any_char());
      end
      if ($urandom_range(0, 3) != 0) add_field(CHAR_LOWER_B, $urandom_range(25, 300));
      repeat ($urandom_range(1, 10)) begin
         if ($urandom_range(0, 99) < 12) song_text.push_back(CHAR_W'($urandom_range(0, 255)));
         case ($urandom_range(0, 5))
            3, 4: add_number(1 << $urandom_range(0, 5));
            5: add_digits($urandom_range(1, 5));
            default: ;
         endcase
         r = $urandom_range(0, 99);
         if (r < 75) song_text.push_back(CHAR_W'(CHAR_LOWER_A + $urandom_range(0, 6)));
         else if (r < 87) song_text.push_back(REST_LETTER);
         else song_text.push_back(non_digit());
         if ($urandom_range(0, 2) == 0) song_text.push_back(CHAR_SHARP);
         if ($urandom_range(0, 3) == 0) song_text.push_back(CHAR_DOT);
         if ($urandom_range(0, 1) == 0)
            song_text.push_back(($urandom_range(0, 4) == 0) ?
                                CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)) :
                                CHAR_W'(CHAR_ZERO + $urandom_range(4, 7)));
         if ($urandom_range(0, 6) != 0) song_text.push_back(CHAR_COMMA);
      end
      if ($urandom_range(0, 7) != 0) song_text.push_back(CHAR_END);
   endfunction

   function automatic void load_directed();
      string head;
      head = "x:d=9999,o=2,b=0:1.p#b#.7c8a0";
      foreach (head[i]) song_text.push_back(head[i]);
      song_text.push_back(8'hFF);
      song_text.push_back(CHAR_END);
      head = ":32";
      foreach (head[i]) song_text.push_back(head[i]);
      song_text.push_back(CHAR_END);
   endfunction

   initial begin : stimulus
      int ph;
      int leftover;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      apply_setting(RESET_DURATION, RESET_OCTAVE, RESET_TEMPO);
      load_directed();
      send_text();
      settle();
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: apply_setting(1, 3, 999);
            1: apply_setting(255, 7, 1);
            3: apply_setting(0, 0, 0);
            5: apply_setting(16, 4, 120);
            default: apply_setting($urandom_range(1, 255), $urandom_range(3, 7),
                                   $urandom_range(1, 999));
         endcase
         if (ph == 1) hold_request = 1'b1;
         while (song_text.size() < PHASE_CHARS) add_song();
         send_text();
         settle();
      end
      leftover = tracker.outstanding();
      $display("Run covered %0d song bytes over %0d register settings, %0d end bytes seen.",
               chars_sent, settings_written, tracker.songs_ended);
      $display("%0d note events checked, %0d mismatches, %0d left over, %0d long hold-offs.",
               tracker.events_checked, tracker.mismatches, leftover, holds_done);
      if (tracker.mismatches == 0 && leftover == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/rtp_pkg.sv
design/rtp_divider.sv
design/rtp_csr.sv
design/rtp_parser.sv
design/rtttl_ringtone_parser.sv
bench/tb_rtttl_ringtone_parser.sv
